### src/sorted_job_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted job queue assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_JOB_QUEUE_DEFINES_SVH
`define SORTED_JOB_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
// The asserting module provides clock and reset.
`define SJQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### src/sjq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted job queue package
// Field widths, result codes and the command that steers the row of cells.
// ----------------------------------------------------------------------------
package sjq_pkg;

   localparam int STATUS_W = 4;
   localparam int EVENT_W  = 2;
   localparam int STATE_W  = 4;
   localparam int REV_W    = 32;
   localparam int SIZE_W   = 7;
   localparam int POS_W    = 6;
   localparam int CAP_W    = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [EVENT_W-1:0]  event_type;

   localparam status_type ST_OK          = 4'd0;
   localparam status_type ST_BAD_ID      = 4'd1;
   localparam status_type ST_BAD_SPEC    = 4'd2;
   localparam status_type ST_BAD_STATE   = 4'd3;
   localparam status_type ST_NOT_QUEUED  = 4'd4;
   localparam status_type ST_BAD_REV     = 4'd5;
   localparam status_type ST_DUPLICATE   = 4'd6;
   localparam status_type ST_FULL        = 4'd7;
   localparam status_type ST_NOT_FOUND   = 4'd8;

   localparam event_type EV_ADMIT_OK   = 2'd0;
   localparam event_type EV_ADMIT_REJ  = 2'd1;
   localparam event_type EV_REMOVE_OK  = 2'd2;
   localparam event_type EV_REMOVE_REJ = 2'd3;

   localparam logic MODE_ADMIT  = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [STATE_W-1:0] JOB_QUEUED     = 4'd0;
   localparam logic [STATE_W-1:0] JOB_LAST_KNOWN = 4'd7;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

### src/sjq_req_if.sv
// ----------------------------------------------------------------------------
// Sorted job queue request channel
// Valid/ready channel carrying one admit or remove request.
// ----------------------------------------------------------------------------
interface sjq_req_if #(
   parameter int ID_BITS   = 32,
   parameter int TIME_BITS = 48
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [ID_BITS-1:0]           job_id;
   logic                         id_valid;
   logic                         spec_ok;
   logic [sjq_pkg::STATE_W-1:0]  job_state;
   logic [sjq_pkg::REV_W-1:0]    revision;
   logic [TIME_BITS-1:0]         submit_stamp;

   modport source (
      output valid, mode, job_id, id_valid, spec_ok, job_state, revision, submit_stamp,
      input  ready
   );

   modport sink (
      input  valid, mode, job_id, id_valid, spec_ok, job_state, revision, submit_stamp,
      output ready
   );
endinterface

### src/sjq_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted job queue response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface sjq_rsp_if #(
   parameter int ID_BITS   = 32,
   parameter int TIME_BITS = 48
);
   logic                          valid;
   logic                          ready;
   logic [sjq_pkg::STATUS_W-1:0]  status;
   logic [sjq_pkg::EVENT_W-1:0]   event_res;
   logic [sjq_pkg::SIZE_W-1:0]    fill_prior;
   logic [sjq_pkg::SIZE_W-1:0]    fill_post;
   logic [sjq_pkg::POS_W-1:0]     position;
   logic                          position_valid;
   logic                          head_valid;
   logic [ID_BITS-1:0]            head_id;
   logic [TIME_BITS-1:0]          head_time;

   modport source (
      output valid, status, event_res, fill_prior, fill_post, position,
             position_valid, head_valid, head_id, head_time,
      input  ready
   );

   modport sink (
      input  valid, status, event_res, fill_prior, fill_post, position,
             position_valid, head_valid, head_id, head_time,
      output ready
   );
endinterface

### src/sjq_cell.sv
// ----------------------------------------------------------------------------
// Sorted job queue cell
// Holds one entry, compares it with the broadcast key and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sjq_cell #(
   parameter int ID_BITS   = 32,
   parameter int TIME_BITS = 48
) (
   input  logic                  clock,
   input  sjq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic [ID_BITS-1:0]    key_id,
   input  logic [TIME_BITS-1:0]  key_stamp,
   input  logic                  left_before,
   input  logic [ID_BITS-1:0]    left_id,
   input  logic [TIME_BITS-1:0]  left_stamp,
   input  logic                  rem_shift,
   input  logic [ID_BITS-1:0]    right_id,
   input  logic [TIME_BITS-1:0]  right_stamp,
   output logic [ID_BITS-1:0]    id,
   output logic [TIME_BITS-1:0]  stamp,
   output logic [ID_BITS-1:0]    nxt_id,
   output logic [TIME_BITS-1:0]  nxt_stamp,
   output logic                  ahead,
   output logic                  match
);
   import sjq_pkg::*;

   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic                 before_ff, before_in;
   logic                 match_ff, match_in;

   always_comb begin
      id_in     = id_ff;
      stamp_in  = stamp_ff;
      before_in = before_ff;
      match_in  = match_ff;
      if (cmd.compare) begin
         match_in  = occupied && (id_ff == key_id);
         before_in = occupied && ((stamp_ff < key_stamp) ||
                                  ((stamp_ff == key_stamp) && (id_ff < key_id)));
      end
      // The new entry lands in the first cell that does not sort before it;
      // every later cell takes the entry of its left neighbor.
      if (cmd.insert && !before_ff) begin
         if (left_before) begin
            id_in    = key_id;
            stamp_in = key_stamp;
         end else begin
            id_in    = left_id;
            stamp_in = left_stamp;
         end
      end
      // From the matching cell onward every cell takes its right neighbor.
      if (cmd.remove && rem_shift) begin
         id_in    = right_id;
         stamp_in = right_stamp;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      stamp_ff  <= stamp_in;
      before_ff <= before_in;
      match_ff  <= match_in;
   end

   assign id        = id_ff;
   assign stamp     = stamp_ff;
   assign nxt_id    = id_in;
   assign nxt_stamp = stamp_in;
   assign ahead     = before_ff;
   assign match     = match_ff;

endmodule

### src/sjq_onehot_enc.sv
// ----------------------------------------------------------------------------
// Sorted job queue one-hot encoder
// Turns a one-hot cell select into the binary cell index.
// ----------------------------------------------------------------------------
module sjq_onehot_enc #(
   parameter int N = 64
) (
   input  logic [N-1:0]         onehot,
   output logic [$clog2(N)-1:0] index
);
   localparam int IW = $clog2(N);

   always_comb begin
      index = '0;
      for (int i = 0; i < N; i++) begin
         if (onehot[i]) begin
            index = index | IW'(i);
         end
      end
   end

endmodule

### src/sorted_job_queue.sv
// ----------------------------------------------------------------------------
// Sorted job queue
// Bounded queue of jobs held in submit-time order (ties by job id) in a row
// of cells. Channel req_chan carries admit or remove requests; every request
// yields one transfer on rsp_chan with status, event, sizes before and after,
// the position touched and the head entry after the request.
// A request passes a compare step, where every cell compares its entry with
// the request key in parallel, and an update step, where, once the output
// register is free, the cells shift left or right by one place if the request
// succeeds and the result is registered. The next request is taken in the
// same cycle as that update. The capacity register is written through
// csr_wr_en and csr_wr_data; the user must write it only while the queue is
// idle, as the block itself does not enforce this. Reset empties the queue
// and sets capacity to 64.
// If the receiver stalls, the finished result waits in the output register.
// One more request may still be taken and compared; it then holds in its
// update step until the output register is free, and further requests wait.
// ----------------------------------------------------------------------------
`include "sorted_job_queue_defines.svh"

module sorted_job_queue #(
   parameter int MAX_ENTRIES = 64,
   parameter int ID_BITS     = 32,
   parameter int TIME_BITS   = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   sjq_req_if.sink                     req_chan,
   sjq_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [sjq_pkg::CAP_W-1:0]   csr_wr_data
);
   import sjq_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int LVLS  = $clog2(MAX_ENTRIES);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   typedef struct packed {
      logic                 mode;
      logic [ID_BITS-1:0]   job_id;
      logic                 id_valid;
      logic                 spec_ok;
      logic [STATE_W-1:0]   job_state;
      logic [REV_W-1:0]     revision;
      logic [TIME_BITS-1:0] submit_stamp;
   } req_type;

   typedef struct packed {
      status_type           status;
      event_type            event_res;
      logic [SIZE_W-1:0]    fill_prior;
      logic [SIZE_W-1:0]    fill_post;
      logic [POS_W-1:0]     position;
      logic                 position_valid;
      logic                 head_valid;
      logic [ID_BITS-1:0]   head_id;
      logic [TIME_BITS-1:0] head_time;
   } rsp_type;

   logic [1:0]       state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             req_accept;
   logic             slot_free;
   logic             commit;
   logic             upd_phase;
   logic             row_full;
   cell_cmd_type     cmd;

   logic [ID_BITS-1:0]   cell_id       [MAX_ENTRIES];
   logic [TIME_BITS-1:0] cell_stamp    [MAX_ENTRIES];
   logic [ID_BITS-1:0]   cell_nxt_id   [MAX_ENTRIES];
   logic [TIME_BITS-1:0] cell_nxt_stamp[MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] before_vec;
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES-1:0] occ_vec;
   logic [MAX_ENTRIES-1:0] shift_vec;
   logic [MAX_ENTRIES-1:0] edge_vec;
   logic [MAX_ENTRIES-1:0] pos_sel;
   logic [MAX_ENTRIES-1:0] pre_lvl [LVLS+1];
   logic [IDX_W-1:0]       pos_idx;

   logic             found;
   logic             full;
   status_type       status_val;
   event_type        event_val;
   logic             ok;
   logic [CNT_W-1:0] count_after;
   logic             head_valid;

   // ------------------------------------------------------------------
   // Handshake and sequencing. A result may be registered when the output
   // register is empty or is being taken in the same cycle.
   // ------------------------------------------------------------------
   assign upd_phase      = (state_ff == S_UPD);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign commit         = upd_phase && slot_free;
   assign req_chan.ready = (state_ff == S_IDLE) || commit;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      priority if (req_accept) begin
         state_in = S_CMP;
      end else if (state_ff == S_CMP) begin
         state_in = S_UPD;
      end else if (commit) begin
         state_in = S_IDLE;
      end else begin
         state_in = state_ff;
      end
   end

   always_comb begin
      req_in = req_ff;
      if (req_accept) begin
         req_in.mode         = req_chan.mode;
         req_in.job_id       = req_chan.job_id;
         req_in.id_valid     = req_chan.id_valid;
         req_in.spec_ok      = req_chan.spec_ok;
         req_in.job_state    = req_chan.job_state;
         req_in.revision     = req_chan.revision;
         req_in.submit_stamp = req_chan.submit_stamp;
      end
   end

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   // ------------------------------------------------------------------
   // Row of cells. Cell i is occupied when i is below the entry count.
   // The first cell sees a left neighbor that always sorts before the key;
   // the last cell sees itself as its right neighbor.
   // ------------------------------------------------------------------
   assign cmd.compare = (state_ff == S_CMP);
   assign cmd.insert  = commit && ok && (req_ff.mode == MODE_ADMIT);
   assign cmd.remove  = commit && ok && (req_ff.mode == MODE_REMOVE);

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                 left_before;
      logic [ID_BITS-1:0]   left_id;
      logic [TIME_BITS-1:0] left_stamp;
      logic [ID_BITS-1:0]   right_id;
      logic [TIME_BITS-1:0] right_stamp;

      assign occ_vec[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_before = 1'b1;
         assign left_id     = req_ff.job_id;
         assign left_stamp  = req_ff.submit_stamp;
      end else begin : g_mid
         assign left_before = before_vec[i-1];
         assign left_id     = cell_id[i-1];
         assign left_stamp  = cell_stamp[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_last
         assign right_id    = cell_id[i];
         assign right_stamp = cell_stamp[i];
      end else begin : g_inner
         assign right_id    = cell_id[i+1];
         assign right_stamp = cell_stamp[i+1];
      end

      sjq_cell #(
         .ID_BITS   (ID_BITS),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occ_vec[i]),
         .key_id      (req_ff.job_id),
         .key_stamp   (req_ff.submit_stamp),
         .left_before (left_before),
         .left_id     (left_id),
         .left_stamp  (left_stamp),
         .rem_shift   (shift_vec[i]),
         .right_id    (right_id),
         .right_stamp (right_stamp),
         .id          (cell_id[i]),
         .stamp       (cell_stamp[i]),
         .nxt_id      (cell_nxt_id[i]),
         .nxt_stamp   (cell_nxt_stamp[i]),
         .ahead       (before_vec[i]),
         .match       (match_vec[i])
      );
   end

   // Cells at and after the matching one shift on remove. This is a prefix
   // OR of the match flags, built as a log-depth tree.
   always_comb begin
      pre_lvl[0] = match_vec;
      for (int l = 0; l < LVLS; l++) begin
         pre_lvl[l+1] = pre_lvl[l] | (pre_lvl[l] << (1 << l));
      end
   end
   assign shift_vec = pre_lvl[LVLS];

   // The before flags form a run of ones from cell 0, so the insert slot is
   // the single cell where that run ends.
   assign edge_vec = ~before_vec & {before_vec[MAX_ENTRIES-2:0], 1'b1};
   assign pos_sel  = (req_ff.mode == MODE_REMOVE) ? match_vec : edge_vec;

   sjq_onehot_enc #(
      .N (MAX_ENTRIES)
   ) u_pos_enc (
      .onehot (pos_sel),
      .index  (pos_idx)
   );

   // ------------------------------------------------------------------
   // Checks, in the order that decides which failure is reported.
   // ------------------------------------------------------------------
   assign found    = |match_vec;
   assign row_full = (count_ff == CNT_W'(MAX_ENTRIES));
   assign full     = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || row_full;

   always_comb begin
      status_val = ST_OK;
      if (req_ff.mode == MODE_ADMIT) begin
         priority if (!req_ff.id_valid) begin
            status_val = ST_BAD_ID;
         end else if (!req_ff.spec_ok) begin
            status_val = ST_BAD_SPEC;
         end else if (req_ff.job_state > JOB_LAST_KNOWN) begin
            status_val = ST_BAD_STATE;
         end else if (req_ff.job_state != JOB_QUEUED) begin
            status_val = ST_NOT_QUEUED;
         end else if (req_ff.revision != '0) begin
            status_val = ST_BAD_REV;
         end else if (found) begin
            status_val = ST_DUPLICATE;
         end else if (full) begin
            status_val = ST_FULL;
         end else begin
            status_val = ST_OK;
         end
      end else begin
         priority if (!req_ff.id_valid) begin
            status_val = ST_BAD_ID;
         end else if (!found) begin
            status_val = ST_NOT_FOUND;
         end else begin
            status_val = ST_OK;
         end
      end
   end

   assign ok = (status_val == ST_OK);

   always_comb begin
      unique case ({req_ff.mode, ok})
         {MODE_ADMIT, 1'b1}:  event_val = EV_ADMIT_OK;
         {MODE_ADMIT, 1'b0}:  event_val = EV_ADMIT_REJ;
         {MODE_REMOVE, 1'b1}: event_val = EV_REMOVE_OK;
         default:             event_val = EV_REMOVE_REJ;
      endcase
   end

   always_comb begin
      count_after = count_ff;
      if (ok) begin
         if (req_ff.mode == MODE_ADMIT) begin
            count_after = count_ff + CNT_W'(1);
         end else begin
            count_after = count_ff - CNT_W'(1);
         end
      end
   end

   assign count_in   = commit ? count_after : count_ff;
   assign head_valid = (count_after != '0);

   // ------------------------------------------------------------------
   // Result register. The head is the value cell 0 takes at this edge.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_in = rsp_ff;
      if (commit) begin
         rsp_in.status         = status_val;
         rsp_in.event_res      = event_val;
         rsp_in.fill_prior     = SIZE_W'(count_ff);
         rsp_in.fill_post      = SIZE_W'(count_after);
         rsp_in.position       = ok ? POS_W'(pos_idx) : '0;
         rsp_in.position_valid = ok;
         rsp_in.head_valid     = head_valid;
         rsp_in.head_id        = head_valid ? cell_nxt_id[0] : '0;
         rsp_in.head_time      = head_valid ? cell_nxt_stamp[0] : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.event_res      = rsp_ff.event_res;
   assign rsp_chan.fill_prior     = rsp_ff.fill_prior;
   assign rsp_chan.fill_post      = rsp_ff.fill_post;
   assign rsp_chan.position       = rsp_ff.position;
   assign rsp_chan.position_valid = rsp_ff.position_valid;
   assign rsp_chan.head_valid     = rsp_ff.head_valid;
   assign rsp_chan.head_id        = rsp_ff.head_id;
   assign rsp_chan.head_time      = rsp_ff.head_time;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // Ids in the queue are unique, so at most one cell can match.
   `SJQ_ASSERT_SAME(a_ids_unique, upd_phase, $onehot0(match_vec), "two cells match one id")
   // Sorted cells give exactly one insert slot unless the row is full.
   `SJQ_ASSERT_SAME(a_one_slot, upd_phase && !row_full, $onehot(edge_vec), "no single slot")
   // An insert never overflows the row.
   `SJQ_ASSERT_SAME(a_insert_room, cmd.insert, !row_full, "insert into a full row")
   // A committed request always shows its result in the next cycle.
   `SJQ_ASSERT_NEXT(a_commit_shows, commit, rsp_valid_ff, "result lost after commit")

endmodule
